@@ rtl/core/hrr_pkg.sv @@
`timescale 1ns / 1ps
package hrr_pkg;

	localparam int CW      = 32;  // content and error word width
	localparam int IDX_W   = 7;   // destination index and overlap width
	localparam int CFG_W   = 13;  // widest configuration register
	localparam int CACC_W  = 56;  // content accumulator
	localparam int EACC_W  = 64;  // squared error accumulator, Q64.0
	localparam int DIV_W   = 60;  // serial divider dividend width
	localparam int DIV_R   = 4;   // quotient bits retired per cycle
	localparam int DIV_N   = DIV_W / DIV_R;
	localparam int DCNT_W  = $clog2(DIV_N + 1);

	localparam logic REG_SRC_BINS  = 1'b0;
	localparam logic REG_DEST_BINS = 1'b1;

	typedef enum logic {
		F_IDLE,
		F_WALK
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EDIV,
		B_SQ,
		B_ACC,
		B_PREP,
		B_CDIV,
		B_SQRT,
		B_OUT
	} back_state_t;

	// one overlap of a source bin with a destination bin
	typedef struct packed {
		logic signed [CW-1:0] content;
		logic [CW-1:0]        error;
		logic [IDX_W-1:0]     overlap;
		logic [IDX_W-1:0]     index;
		logic                 emit;
		logic                 last;
	} seg_t;

	typedef struct packed {
		logic [IDX_W-1:0]     index;
		logic signed [CW-1:0] content;
		logic [CW-1:0]        error;
		logic                 saturated;
		logic                 last;
	} res_t;

endpackage

@@ rtl/core/histogram_row_rebinner_top.sv @@
`timescale 1ns / 1ps
// Histogram row rebinner: maps a row of src_bins equal source bins onto
// dest_bins equal destination bins by exact fractional overlap.
// Input channel: push/full, one source bin word (content, error) per push.
// Result channel: empty/pop, one word per completed destination bin, with
// dest_index, rounded content, quadrature error, saturated and last_of_row.
// Configuration: cfg_we/cfg_index/cfg_wdata; any write restarts the row.
// A source word is held by the front end while it walks the destination
// bins it overlaps, handing one overlap segment per bin to a 4-deep queue.
// The back end divides each segment's error with the radix-16 serial
// divider, squares and accumulates it; each finished bin then takes a
// content division and the 32-step square root that runs beside it.
// The front end can take the next source word while the back end still
// works on queued segments.
// Reset clears both registers to 1, restarts the row and empties the
// queues. When the receiver stalls the result queue fills, then the back
// end and the segment queue hold, and finally full stays high.
module histogram_row_rebinner_top
	import hrr_pkg::*;
#(
	parameter int MAX_SRC_BINS = 4096,
	parameter int MAX_DST_BINS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 push,
	output logic                 full,
	input  logic signed [CW-1:0] source_content,
	input  logic [CW-1:0]        source_error,
	output logic                 empty,
	input  logic                 pop,
	output logic [IDX_W-1:0]     dest_index,
	output logic signed [CW-1:0] dest_content,
	output logic [CW-1:0]        dest_error,
	output logic                 saturated,
	output logic                 last_of_row
);

	localparam int SW = $clog2(MAX_SRC_BINS + 1);
	localparam int UW = $clog2(MAX_SRC_BINS * MAX_DST_BINS + 1);

	logic [SW-1:0]    src_q;
	logic [IDX_W-1:0] dst_q;
	logic [31:0]      wv;

	seg_t seg_in, seg_out;
	logic seg_push, seg_full, seg_pop, seg_empty;
	res_t res_in, res_out;
	logic res_push, res_full;

	// clamp writes into range: zero acts as one, large values as the maximum (dest bins use only the low IDX_W bits)
	assign wv = 32'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SW'(1);
			dst_q <= IDX_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_BINS: begin
					if (wv == '0) begin
						src_q <= SW'(1);
					end else if (wv > 32'(MAX_SRC_BINS)) begin
						src_q <= SW'(MAX_SRC_BINS);
					end else begin
						src_q <= SW'(wv);
					end
				end
				REG_DEST_BINS: begin
					if (wv[IDX_W-1:0] == '0) begin
						dst_q <= IDX_W'(1);
					end else if (32'(wv[IDX_W-1:0]) > 32'(MAX_DST_BINS)) begin
						dst_q <= IDX_W'(MAX_DST_BINS);
					end else begin
						dst_q <= wv[IDX_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	hrr_front #(
		.SW(SW),
		.UW(UW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (cfg_we),
		.src            (src_q),
		.dst            (dst_q),
		.push           (push),
		.full           (full),
		.source_content (source_content),
		.source_error   (source_error),
		.seg_push       (seg_push),
		.seg            (seg_in),
		.seg_full       (seg_full)
	);

	hrr_fifo #(
		.WIDTH($bits(seg_t)),
		.DEPTH(4)
	) u_seg_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (seg_push),
		.din   (seg_in),
		.full  (seg_full),
		.rd    (seg_pop),
		.dout  (seg_out),
		.empty (seg_empty)
	);

	hrr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.dst      (dst_q),
		.seg      (seg_out),
		.seg_empty(seg_empty),
		.seg_pop  (seg_pop),
		.res      (res_in),
		.res_push (res_push),
		.res_full (res_full)
	);

	hrr_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.din   (res_in),
		.full  (res_full),
		.rd    (pop),
		.dout  (res_out),
		.empty (empty)
	);

	assign dest_index   = res_out.index;
	assign dest_content = res_out.content;
	assign dest_error   = res_out.error;
	assign saturated    = res_out.saturated;
	assign last_of_row  = res_out.last;

endmodule

@@ rtl/core/hrr_fifo.sv @@
`timescale 1ns / 1ps
module hrr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = cnt_q == NW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/hrr_front.sv @@
`timescale 1ns / 1ps
module hrr_front
	import hrr_pkg::*;
#(
	parameter int SW = 13,
	parameter int UW = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [SW-1:0]        src,
	input  logic [IDX_W-1:0]     dst,
	input  logic                 push,
	output logic                 full,
	input  logic signed [CW-1:0] source_content,
	input  logic [CW-1:0]        source_error,
	output logic                 seg_push,
	output seg_t                 seg,
	input  logic                 seg_full
);

	front_state_t st_q, st_nx;

	logic [SW-1:0]        s_cnt_q;
	logic [UW-1:0]        s_lo_q, d_lo_q;
	logic [IDX_W-1:0]     dpos_q;
	logic signed [CW-1:0] content_q;
	logic [CW-1:0]        error_q;

	logic [UW-1:0] s_hi, d_hi, lo, hi;
	logic          emit, fin, row_end;

	assign s_hi    = s_lo_q + UW'(dst);
	assign d_hi    = d_lo_q + UW'(src);
	assign lo      = (s_lo_q > d_lo_q) ? s_lo_q : d_lo_q;
	assign hi      = (s_hi < d_hi) ? s_hi : d_hi;
	assign emit    = d_hi <= s_hi;
	assign fin     = !emit || (d_hi == s_hi);
	assign row_end = s_cnt_q == src - 1'b1;

	assign seg.content = content_q;
	assign seg.error   = error_q;
	assign seg.overlap = (hi > lo) ? IDX_W'(hi - lo) : '0;
	assign seg.index   = dpos_q;
	assign seg.emit    = emit;
	assign seg.last    = emit && (dpos_q == dst);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			F_IDLE: if (push) st_nx = F_WALK;
			F_WALK: if (!seg_full && fin) st_nx = F_IDLE;
			default: st_nx = F_IDLE;
		endcase
	end

	always_comb begin
		full     = st_q != F_IDLE;
		seg_push = (st_q == F_WALK) && !seg_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && push) begin
			content_q <= source_content;
			error_q   <= source_error;
		end
	end

	// walk the destination bins that the held source bin overlaps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_cnt_q <= '0;
			s_lo_q  <= '0;
			d_lo_q  <= '0;
			dpos_q  <= IDX_W'(1);
		end else if (restart) begin
			s_cnt_q <= '0;
			s_lo_q  <= '0;
			d_lo_q  <= '0;
			dpos_q  <= IDX_W'(1);
		end else if (seg_push) begin
			if (fin && row_end) begin
				s_cnt_q <= '0;
				s_lo_q  <= '0;
				d_lo_q  <= '0;
				dpos_q  <= IDX_W'(1);
			end else begin
				if (emit) begin
					d_lo_q <= d_hi;
					dpos_q <= dpos_q + 1'b1;
				end
				if (fin) begin
					s_cnt_q <= s_cnt_q + 1'b1;
					s_lo_q  <= s_hi;
				end
			end
		end
	end

endmodule

@@ rtl/core/hrr_back.sv @@
`timescale 1ns / 1ps
module hrr_back
	import hrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [IDX_W-1:0] dst,
	input  seg_t             seg,
	input  logic             seg_empty,
	output logic             seg_pop,
	output res_t             res,
	output logic             res_push,
	input  logic             res_full
);

	back_state_t st_q, st_nx;

	seg_t                     seg_q;
	logic signed [CACC_W-1:0] cacc_q;
	logic [EACC_W-1:0]        eacc_q;
	logic [2*CW-1:0]          sq_q;
	logic                     neg_q;

	logic [DIV_W-1:0]  dq_q, dq_nx;
	logic [IDX_W:0]    dr_q, dr_nx;
	logic [DCNT_W-1:0] dcnt_q;

	logic [EACC_W-1:0] sv_q, sres_q, sbit_q, st_sum;
	logic              sq_done;

	logic [CW+IDX_W-1:0]      eprod;
	logic signed [CACC_W-1:0] cprod;
	logic [CACC_W-1:0]        cmag;
	logic [EACC_W:0]          esum;
	logic [CW:0]              rnd;

	// radix-16 restoring division by the destination count
	always_comb begin
		logic [IDX_W:0]   r, r2;
		logic [DIV_W-1:0] q;
		r = dr_q;
		q = dq_q;
		for (int i = 0; i < DIV_R; i++) begin
			r2 = {r[IDX_W-1:0], q[DIV_W-1]};
			q  = {q[DIV_W-2:0], 1'b0};
			if (r2 >= {1'b0, dst}) begin
				r    = r2 - {1'b0, dst};
				q[0] = 1'b1;
			end else begin
				r = r2;
			end
		end
		dr_nx = r;
		dq_nx = q;
	end

	assign eprod   = seg.error * seg.overlap;
	assign cprod   = CACC_W'(seg_q.content) * $signed({1'b0, seg_q.overlap});
	assign cmag    = cacc_q[CACC_W-1] ? CACC_W'(-cacc_q) : CACC_W'(cacc_q);
	assign esum    = {1'b0, eacc_q} + {1'b0, sq_q};
	assign st_sum  = sres_q + sbit_q;
	assign sq_done = sbit_q == '0;

	// round the root up when the remainder exceeds it
	assign rnd = (sv_q > sres_q) ? {1'b0, sres_q[CW-1:0]} + 1'b1 : {1'b0, sres_q[CW-1:0]};

	always_comb begin
		logic csat, esat;
		if (neg_q) begin
			csat = dq_q > DIV_W'(64'h8000_0000);
		end else begin
			csat = dq_q > DIV_W'(64'h7FFF_FFFF);
		end
		esat          = rnd[CW] || (sres_q[EACC_W-1:CW] != '0);
		res.index     = seg_q.index;
		res.last      = seg_q.last;
		res.saturated = csat || esat;
		res.error     = esat ? '1 : rnd[CW-1:0];
		if (neg_q) begin
			res.content = csat ? $signed(32'h8000_0000) : $signed(CW'(-dq_q[CW-1:0]));
		end else begin
			res.content = csat ? $signed(32'h7FFF_FFFF) : $signed(dq_q[CW-1:0]);
		end
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			B_IDLE: if (!seg_empty) st_nx = B_EDIV;
			B_EDIV: if (dcnt_q == DCNT_W'(1)) st_nx = B_SQ;
			B_SQ:   st_nx = B_ACC;
			B_ACC:  st_nx = seg_q.emit ? B_PREP : B_IDLE;
			B_PREP: st_nx = B_CDIV;
			B_CDIV: if (dcnt_q == DCNT_W'(1)) st_nx = B_SQRT;
			B_SQRT: if (sq_done) st_nx = B_OUT;
			B_OUT:  if (!res_full) st_nx = B_IDLE;
			default: st_nx = B_IDLE;
		endcase
	end

	always_comb begin
		seg_pop  = (st_q == B_IDLE) && !seg_empty;
		res_push = (st_q == B_OUT) && !res_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cacc_q <= '0;
			eacc_q <= '0;
		end else if (restart) begin
			cacc_q <= '0;
			eacc_q <= '0;
		end else if (st_q == B_ACC) begin
			cacc_q <= cacc_q + cprod;
			eacc_q <= esum[EACC_W] ? '1 : esum[EACC_W-1:0];
		end else if (st_q == B_PREP) begin
			cacc_q <= '0;
			eacc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				seg_q  <= seg;
				dq_q   <= DIV_W'(eprod) + DIV_W'(dst >> 1);
				dr_q   <= '0;
				dcnt_q <= DCNT_W'(DIV_N);
			end
			B_EDIV, B_CDIV: begin
				dq_q   <= dq_nx;
				dr_q   <= dr_nx;
				dcnt_q <= dcnt_q - 1'b1;
			end
			B_SQ: sq_q <= dq_q[CW-1:0] * dq_q[CW-1:0];
			B_PREP: begin
				neg_q  <= cacc_q[CACC_W-1];
				dq_q   <= DIV_W'(cmag) + DIV_W'(dst >> 1);
				dr_q   <= '0;
				dcnt_q <= DCNT_W'(DIV_N);
			end
			default: ;
		endcase
	end

	// bit-pair square root, one step per cycle, runs beside the divider
	always_ff @(posedge clk) begin
		if (st_q == B_PREP) begin
			sv_q   <= eacc_q;
			sres_q <= '0;
			sbit_q <= EACC_W'(1) << (EACC_W - 2);
		end else if (!sq_done) begin
			if (sv_q >= st_sum) begin
				sv_q   <= sv_q - st_sum;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

endmodule
